[hdl/arsp_pkg.sv]
// shared types and codes for the administrative record stream parser
package arsp_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        field_valid;
      logic [3:0]  field_id;
      logic [63:0] field_value;
      logic [1:0]  record_status;
      logic [1:0]  error_code;
   } rsp_type;

   localparam logic [3:0] FID_HEADER   = 4'd0;
   localparam logic [3:0] FID_FLAGS    = 4'd1;
   localparam logic [3:0] FID_REASON   = 4'd2;
   localparam logic [3:0] FID_CUSTODY  = 4'd3;
   localparam logic [3:0] FID_FOFF     = 4'd4;
   localparam logic [3:0] FID_FLEN     = 4'd5;
   localparam logic [3:0] FID_EVS      = 4'd6;
   localparam logic [3:0] FID_EVNS     = 4'd7;
   localparam logic [3:0] FID_CTS      = 4'd8;
   localparam logic [3:0] FID_SEQ      = 4'd9;
   localparam logic [3:0] FID_EIDLEN   = 4'd10;
   localparam logic [3:0] FID_EID      = 4'd11;

   localparam logic [1:0] PS_BUSY      = 2'd0;
   localparam logic [1:0] PS_DONE      = 2'd1;
   localparam logic [1:0] PS_ERROR     = 2'd2;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_TYPE     = 2'd1;
   localparam logic [1:0] ERR_OVERFLOW = 2'd2;
   localparam logic [1:0] ERR_TRUNC    = 2'd3;

   localparam logic [3:0] TYPE_STATUS  = 4'd1;
   localparam logic [3:0] TYPE_CUSTODY = 4'd2;

endpackage

[hdl/arsp_in_reg.sv]
// input register stage holding one request transaction
module arsp_in_reg
   import arsp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    item_valid,
   input  logic    item_ready,
   output req_type item_data
);

   logic    valid_ff, valid_in;
   req_type data_ff;

   assign req_ready  = !valid_ff || item_ready;
   assign item_valid = valid_ff;
   assign item_data  = data_ff;

   always_comb begin
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (item_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

endmodule

[hdl/arsp_parser.sv]
// record parse state and per-byte decode logic
module arsp_parser
   import arsp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  req_type item,
   output rsp_type result
);

   typedef enum logic [12:0] {
      ST_HEADER  = 13'b0000000000001,
      ST_FLAGS   = 13'b0000000000010,
      ST_REASON  = 13'b0000000000100,
      ST_CUSTODY = 13'b0000000001000,
      ST_FOFF    = 13'b0000000010000,
      ST_FLEN    = 13'b0000000100000,
      ST_EVS     = 13'b0000001000000,
      ST_EVNS    = 13'b0000010000000,
      ST_CTS     = 13'b0000100000000,
      ST_SEQ     = 13'b0001000000000,
      ST_EIDLEN  = 13'b0010000000000,
      ST_EID     = 13'b0100000000000,
      ST_DRAIN   = 13'b1000000000000
   } stage_type;

   stage_type   stage_ff, stage_in;
   logic [3:0]  flags_ff, flags_in;
   logic [63:0] acc_ff, acc_in;
   logic [15:0] eid_left_ff, eid_left_in;
   logic [15:0] eid_dec;
   logic [1:0]  status_ff, status_in;
   logic [1:0]  err_ff, err_in;

   logic [7:0]  byte_val;
   logic [63:0] acc_shift;
   logic        ovf16, ovf32, ovf64;
   logic        ovf, more;
   stage_type   after_prefix;

   assign byte_val     = item.data_byte;
   assign acc_shift    = {acc_ff[56:0], byte_val[6:0]};
   assign ovf16        = |acc_ff[63:9];
   assign ovf32        = |acc_ff[63:25];
   assign ovf64        = |acc_ff[63:57];
   assign more         = byte_val[7];
   assign after_prefix = flags_ff[0] ? ST_FOFF : ST_EVS;
   assign eid_dec      = eid_left_ff - 16'd1;

   always_comb begin
      stage_in            = stage_ff;
      flags_in            = flags_ff;
      acc_in              = acc_ff;
      eid_left_in         = eid_left_ff;
      status_in           = status_ff;
      err_in              = err_ff;
      result.field_valid  = 1'b0;
      result.field_id     = FID_HEADER;
      result.field_value  = 64'd0;
      ovf                 = 1'b0;

      case (stage_ff)
         ST_FOFF, ST_FLEN, ST_EVNS: ovf = ovf32;
         ST_EVS, ST_CTS:            ovf = ovf64;
         ST_SEQ, ST_EIDLEN:         ovf = ovf16;
         default:                   ovf = 1'b0;
      endcase

      case (stage_ff)
         ST_HEADER: begin
            flags_in = byte_val[3:0];
            if (byte_val[7:4] == TYPE_STATUS) begin
               result.field_valid = 1'b1;
               result.field_value = {56'd0, byte_val};
               stage_in           = ST_FLAGS;
            end else if (byte_val[7:4] == TYPE_CUSTODY) begin
               result.field_valid = 1'b1;
               result.field_value = {56'd0, byte_val};
               stage_in           = ST_CUSTODY;
            end else begin
               status_in = PS_ERROR;
               err_in    = ERR_TYPE;
               stage_in  = ST_DRAIN;
            end
         end
         ST_FLAGS: begin
            result.field_valid = 1'b1;
            result.field_id    = FID_FLAGS;
            result.field_value = {56'd0, byte_val};
            stage_in           = ST_REASON;
         end
         ST_REASON: begin
            result.field_valid = 1'b1;
            result.field_id    = FID_REASON;
            result.field_value = {56'd0, byte_val};
            stage_in           = after_prefix;
         end
         ST_CUSTODY: begin
            result.field_valid = 1'b1;
            result.field_id    = FID_CUSTODY;
            result.field_value = {56'd0, byte_val};
            stage_in           = after_prefix;
         end
         ST_FOFF, ST_FLEN, ST_EVS, ST_EVNS, ST_CTS, ST_SEQ, ST_EIDLEN: begin
            if (ovf) begin
               status_in = PS_ERROR;
               err_in    = ERR_OVERFLOW;
               stage_in  = ST_DRAIN;
            end else if (more) begin
               acc_in = acc_shift;
            end else begin
               acc_in             = 64'd0;
               result.field_valid = 1'b1;
               result.field_value = acc_shift;
               case (stage_ff)
                  ST_FOFF: begin
                     result.field_id = FID_FOFF;
                     stage_in        = ST_FLEN;
                  end
                  ST_FLEN: begin
                     result.field_id = FID_FLEN;
                     stage_in        = ST_EVS;
                  end
                  ST_EVS: begin
                     result.field_id = FID_EVS;
                     stage_in        = ST_EVNS;
                  end
                  ST_EVNS: begin
                     result.field_id = FID_EVNS;
                     stage_in        = ST_CTS;
                  end
                  ST_CTS: begin
                     result.field_id = FID_CTS;
                     stage_in        = ST_SEQ;
                  end
                  ST_SEQ: begin
                     result.field_id = FID_SEQ;
                     stage_in        = ST_EIDLEN;
                  end
                  default: begin
                     result.field_id = FID_EIDLEN;
                     eid_left_in     = acc_shift[15:0];
                     if (acc_shift[15:0] == 16'd0) begin
                        status_in = PS_DONE;
                        stage_in  = ST_DRAIN;
                     end else begin
                        stage_in = ST_EID;
                     end
                  end
               endcase
            end
         end
         ST_EID: begin
            result.field_valid = 1'b1;
            result.field_id    = FID_EID;
            result.field_value = {56'd0, byte_val};
            eid_left_in        = eid_dec;
            if (eid_dec == 16'd0) begin
               status_in = PS_DONE;
               stage_in  = ST_DRAIN;
            end
         end
         default: begin
            stage_in = ST_DRAIN;
         end
      endcase

      if (item.last_byte && status_in == PS_BUSY) begin
         result.record_status = PS_ERROR;
         result.error_code    = ERR_TRUNC;
      end else begin
         result.record_status = status_in;
         result.error_code    = err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && item.last_byte)) begin
         stage_ff    <= ST_HEADER;
         flags_ff    <= 4'd0;
         acc_ff      <= 64'd0;
         eid_left_ff <= 16'd0;
         status_ff   <= PS_BUSY;
         err_ff      <= ERR_NONE;
      end else if (advance) begin
         stage_ff    <= stage_in;
         flags_ff    <= flags_in;
         acc_ff      <= acc_in;
         eid_left_ff <= eid_left_in;
         status_ff   <= status_in;
         err_ff      <= err_in;
      end
   end

endmodule

[hdl/arsp_out_reg.sv]
// result register holding one response transaction
module arsp_out_reg
   import arsp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load_valid,
   output logic    load_ready,
   input  rsp_type load_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign load_ready = !valid_ff || rsp_ready;
   assign rsp_valid  = valid_ff;
   assign rsp_data   = data_ff;

   always_comb begin
      if (load_valid && load_ready) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_valid && load_ready) begin
         data_ff <= load_data;
      end
   end

endmodule

[hdl/admin_record_stream_parser.sv]
// top level of the administrative record stream parser
//
// req channel: one payload byte per transaction, last_byte marks the end
// of the record; the parser starts over after that byte.
// rsp channel: exactly one result per request byte, in order, carrying
// the field finished by that byte (if any) and the record status.
// path: an accepted byte is held in the input register, decoded
// combinationally and loaded into the result register, which drives
// rsp_valid and rsp_data.
// throughput: one byte per cycle while rsp_ready is high; the decode
// between the input register and the result register is combinational.
// stall: when rsp_ready is low the result register holds, the input
// register still takes one more byte, then req_ready drops until the
// receiver takes the pending result.
// reset: synchronous, clears both registers and returns the parser to
// waiting for a header byte.
module admin_record_stream_parser
   import arsp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    item_valid;
   logic    item_ready;
   req_type item_data;
   rsp_type result;

   arsp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item_data  (item_data)
   );

   arsp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (item_valid && item_ready),
      .item    (item_data),
      .result  (result)
   );

   arsp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (item_valid),
      .load_ready (item_ready),
      .load_data  (result),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   a_err_means_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error_code != ERR_NONE |-> rsp_data.record_status == PS_ERROR)
      else $error("error code without error status");

   a_error_has_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.record_status == PS_ERROR |-> rsp_data.error_code != ERR_NONE)
      else $error("error status without error code");

   a_idle_field_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.field_valid
         |-> rsp_data.field_id == FID_HEADER && rsp_data.field_value == 64'd0)
      else $error("non-field result carries data");

   a_field_id_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.field_valid |-> rsp_data.field_id <= FID_EID)
      else $error("field id out of range");

endmodule

[dv/admin_record_stream_parser_tb.sv]
// testbench for the administrative record stream parser: byte-level predictor with checking
`timescale 1ns / 1ps

module admin_record_stream_parser_tb;
   import arsp_pkg::*;

   typedef enum logic [3:0] {
      STG_HEADER, STG_FLAGS, STG_REASON, STG_CUSTODY, STG_FOFF, STG_FLEN, STG_EVS,
      STG_EVNS, STG_CTS, STG_SEQ, STG_EIDLEN, STG_EID, STG_DRAIN
   } parse_stage_type;

   typedef enum int {
      REC_GOOD, REC_TRAILING, REC_TRUNC, REC_OVERFLOW, REC_BADTYPE, REC_NOISE
   } rec_kind_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   admin_record_stream_parser uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   req_type     pending_bytes[$];
   rsp_type     expected_results[$];
   logic [7:0]  rec_bytes[$];
   int unsigned mismatch_count = 0;

   // predictor state
   parse_stage_type cur_stage;
   logic [3:0]      hdr_flags;
   logic [63:0]     sdnv_acc;
   logic [15:0]     eid_left;
   logic [1:0]      rec_status;
   logic [1:0]      rec_error;

   function automatic void parser_restart();
      cur_stage  = STG_HEADER;
      hdr_flags  = '0;
      sdnv_acc   = '0;
      eid_left   = '0;
      rec_status = PS_BUSY;
      rec_error  = ERR_NONE;
   endfunction

   function automatic logic sdnv_take(input int unsigned width, input logic [7:0] b,
                                      output logic [63:0] val);
      val = '0;
      if ((sdnv_acc >> (width - 7)) != 64'd0) begin
         rec_status = PS_ERROR;
         rec_error  = ERR_OVERFLOW;
         cur_stage  = STG_DRAIN;
         return 1'b0;
      end
      sdnv_acc = (sdnv_acc << 7) | {57'd0, b[6:0]};
      if (b[7])
         return 1'b0;
      val = sdnv_acc;
      sdnv_acc = '0;
      return 1'b1;
   endfunction

   function automatic rsp_type decode_byte(input req_type item);
      rsp_type         r;
      logic [7:0]      b;
      logic [63:0]     v;
      logic            sdnv_field;
      int unsigned     w;
      logic [3:0]      fid;
      parse_stage_type nxt;
      r = '0;
      b = item.data_byte;
      sdnv_field = 1'b0;
      w = 64;
      fid = FID_HEADER;
      nxt = STG_DRAIN;
      case (cur_stage)
         STG_HEADER: begin
            hdr_flags = b[3:0];
            if (b[7:4] == TYPE_STATUS) begin
               r.field_valid = 1'b1;
               r.field_id = FID_HEADER;
               r.field_value = {56'd0, b};
               cur_stage = STG_FLAGS;
            end else if (b[7:4] == TYPE_CUSTODY) begin
               r.field_valid = 1'b1;
               r.field_id = FID_HEADER;
               r.field_value = {56'd0, b};
               cur_stage = STG_CUSTODY;
            end else begin
               rec_status = PS_ERROR;
               rec_error  = ERR_TYPE;
               cur_stage  = STG_DRAIN;
            end
         end
         STG_FLAGS: begin
            r.field_valid = 1'b1;
            r.field_id = FID_FLAGS;
            r.field_value = {56'd0, b};
            cur_stage = STG_REASON;
         end
         STG_REASON, STG_CUSTODY: begin
            r.field_valid = 1'b1;
            r.field_id = (cur_stage == STG_REASON) ? FID_REASON : FID_CUSTODY;
            r.field_value = {56'd0, b};
            cur_stage = hdr_flags[0] ? STG_FOFF : STG_EVS;
         end
         STG_FOFF: begin
            sdnv_field = 1'b1; w = 32; fid = FID_FOFF; nxt = STG_FLEN;
         end
         STG_FLEN: begin
            sdnv_field = 1'b1; w = 32; fid = FID_FLEN; nxt = STG_EVS;
         end
         STG_EVS: begin
            sdnv_field = 1'b1; w = 64; fid = FID_EVS; nxt = STG_EVNS;
         end
         STG_EVNS: begin
            sdnv_field = 1'b1; w = 32; fid = FID_EVNS; nxt = STG_CTS;
         end
         STG_CTS: begin
            sdnv_field = 1'b1; w = 64; fid = FID_CTS; nxt = STG_SEQ;
         end
         STG_SEQ: begin
            sdnv_field = 1'b1; w = 16; fid = FID_SEQ; nxt = STG_EIDLEN;
         end
         STG_EIDLEN: begin
            if (sdnv_take(16, b, v)) begin
               r.field_valid = 1'b1;
               r.field_id = FID_EIDLEN;
               r.field_value = v;
               eid_left = v[15:0];
               if (eid_left == 16'd0) begin
                  rec_status = PS_DONE;
                  cur_stage = STG_DRAIN;
               end else begin
                  cur_stage = STG_EID;
               end
            end
         end
         STG_EID: begin
            r.field_valid = 1'b1;
            r.field_id = FID_EID;
            r.field_value = {56'd0, b};
            eid_left = eid_left - 16'd1;
            if (eid_left == 16'd0) begin
               rec_status = PS_DONE;
               cur_stage = STG_DRAIN;
            end
         end
         default: begin
            cur_stage = STG_DRAIN;
         end
      endcase
      if (sdnv_field && sdnv_take(w, b, v)) begin
         r.field_valid = 1'b1;
         r.field_id = fid;
         r.field_value = v;
         cur_stage = nxt;
      end
      r.record_status = rec_status;
      r.error_code = rec_error;
      if (item.last_byte && rec_status == PS_BUSY) begin
         r.record_status = PS_ERROR;
         r.error_code = ERR_TRUNC;
      end
      if (item.last_byte)
         parser_restart();
      return r;
   endfunction

   // stimulus helpers
   function automatic void push_item(input logic [7:0] b, input logic last);
      req_type t;
      t.data_byte = b;
      t.last_byte = last;
      pending_bytes.push_back(t);
   endfunction

   function automatic logic [63:0] rand_field(input int unsigned width);
      logic [63:0] r;
      int unsigned nb;
      case ($urandom_range(0, 5))
         0: r = '0;
         1: r = (width == 64) ? '1 : ((64'd1 << width) - 64'd1);
         default: begin
            nb = $urandom_range(1, width);
            r = {$urandom, $urandom};
            if (nb < 64)
               r = r & ((64'd1 << nb) - 64'd1);
         end
      endcase
      return r;
   endfunction

   function automatic void put_sdnv(input logic [63:0] v);
      int          n;
      logic [63:0] tmp;
      n = 1;
      tmp = v >> 7;
      while (tmp != 0) begin
         n++;
         tmp = tmp >> 7;
      end
      if ($urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 2)) rec_bytes.push_back(8'h80);
      for (int i = n - 1; i >= 0; i--)
         rec_bytes.push_back({(i != 0), 7'(v >> (7 * i))});
   endfunction

   function automatic void build_record(input rec_kind_type kind);
      logic [7:0]  hdr;
      logic [63:0] len;
      int          bad;
      int          cut;
      int unsigned w;
      rec_bytes.delete();
      if (kind == REC_NOISE) begin
         repeat ($urandom_range(1, 5)) push_item(8'($urandom), ($urandom_range(0, 3) == 0));
         push_item(8'($urandom), 1'b1);
         return;
      end
      if (kind == REC_BADTYPE) begin
         hdr = 8'($urandom);
         while (hdr[7:4] == TYPE_STATUS || hdr[7:4] == TYPE_CUSTODY)
            hdr = 8'($urandom);
         rec_bytes.push_back(hdr);
         repeat ($urandom_range(0, 3)) rec_bytes.push_back(8'($urandom));
      end else begin
         hdr = {($urandom_range(0, 1) ? TYPE_STATUS : TYPE_CUSTODY), 4'($urandom)};
         bad = (kind == REC_OVERFLOW) ? $urandom_range(0, 6) : -1;
         if (bad >= 0 && bad < 2)
            hdr[0] = 1'b1;
         rec_bytes.push_back(hdr);
         rec_bytes.push_back(8'($urandom));
         if (hdr[7:4] == TYPE_STATUS)
            rec_bytes.push_back(8'($urandom));
         for (int f = 0; f < 7; f++) begin
            if (f < 2 && !hdr[0])
               continue;
            case (f)
               2, 4:    w = 64;
               5, 6:    w = 16;
               default: w = 32;
            endcase
            if (f == bad) begin
               repeat ((w + 6) / 7 + 1) rec_bytes.push_back(8'hFF);
               repeat ($urandom_range(0, 3)) rec_bytes.push_back(8'($urandom));
               break;
            end
            if (f == 6) begin
               len = ($urandom_range(0, 59) == 0) ? 64'($urandom_range(100, 300))
                                                  : 64'($urandom_range(0, 6));
               put_sdnv(len);
               repeat (int'(len)) rec_bytes.push_back(8'($urandom));
            end else begin
               put_sdnv(rand_field(w));
            end
         end
         if (kind == REC_TRAILING)
            repeat ($urandom_range(1, 3)) rec_bytes.push_back(8'($urandom));
         if (kind == REC_TRUNC) begin
            cut = $urandom_range(1, rec_bytes.size() - 1);
            while (rec_bytes.size() > cut)
               void'(rec_bytes.pop_back());
         end
      end
      foreach (rec_bytes[i])
         push_item(rec_bytes[i], (i == rec_bytes.size() - 1));
   endfunction

   // sender
   int unsigned burst_left = 1;
   int unsigned gap_left = 0;

   always @(posedge clock) begin
      logic hold;
      hold = req_valid && !req_ready;
      if (req_valid && req_ready)
         expected_results.push_back(decode_byte(pending_bytes.pop_front()));
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!hold) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            req_valid <= 1'b1;
            req_data <= pending_bytes[0];
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 64);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver and checker
   int unsigned rx_cycle = 0;
   int unsigned rx_hold = 0;
   int unsigned rx_mode = 0;
   int unsigned rx_mode_left = 50;

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = rsp_data;
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: valid=%0b id=%0d value=%h status=%0d err=%0d",
                        got.field_valid, got.field_id, got.field_value,
                        got.record_status, got.error_code);
         end else begin
            want = expected_results.pop_front();
            if (got.field_valid !== want.field_valid || got.field_id !== want.field_id ||
                got.field_value !== want.field_value ||
                got.record_status !== want.record_status ||
                got.error_code !== want.error_code) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: exp valid=%0b id=%0d value=%h status=%0d err=%0d",
                           want.field_valid, want.field_id, want.field_value,
                           want.record_status, want.error_code);
                  $display("          got valid=%0b id=%0d value=%h status=%0d err=%0d",
                           got.field_valid, got.field_id, got.field_value,
                           got.record_status, got.error_code);
               end
            end
         end
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rx_cycle++;
         // long hold-off so the block backs up into the request side
         if (rx_cycle == 600 || rx_cycle == 1500)
            rx_hold = 400;
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_ready <= 1'b0;
         end else begin
            case (rx_mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
         if (rx_mode_left > 1) begin
            rx_mode_left--;
         end else begin
            rx_mode = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(20, 200);
         end
      end
   end

   initial begin
      int unsigned  random_count;
      rec_kind_type kind;
      int unsigned  pick;
      int unsigned  roll;
      parser_restart();
      // minimal custody signal with zero eid length, then a byte after completion
      push_item(8'h20, 1'b0);
      push_item(8'h85, 1'b0);
      repeat (5) push_item(8'h00, 1'b0);
      push_item(8'hFF, 1'b1);
      // unknown record types
      push_item(8'hF0, 1'b1);
      push_item(8'h00, 1'b1);
      // status report cut short
      push_item(8'h1F, 1'b0);
      push_item(8'h00, 1'b0);
      push_item(8'hFF, 1'b1);
      // fragment offset too wide for 32 bits
      push_item(8'h21, 1'b0);
      push_item(8'h7F, 1'b0);
      repeat (5) push_item(8'hFF, 1'b0);
      push_item(8'h00, 1'b1);
      random_count = 0;
      while (random_count < 1800) begin
         pick = pending_bytes.size();
         roll = $urandom_range(0, 99);
         if (roll < 55)
            kind = REC_GOOD;
         else if (roll < 70)
            kind = REC_TRAILING;
         else if (roll < 80)
            kind = REC_TRUNC;
         else if (roll < 88)
            kind = REC_OVERFLOW;
         else if (roll < 94)
            kind = REC_BADTYPE;
         else
            kind = REC_NOISE;
         build_record(kind);
         random_count += pending_bytes.size() - pick;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (pending_bytes.size() == 0);
      wait (expected_results.size() == 0);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

[filelist.f]
hdl/arsp_pkg.sv
hdl/arsp_in_reg.sv
hdl/arsp_parser.sv
hdl/arsp_out_reg.sv
hdl/admin_record_stream_parser.sv
dv/admin_record_stream_parser_tb.sv
